### sv/bitmap_page_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Bitmap page allocator - assertion macros
// Same-cycle and next-cycle implication checks with asynchronous reset gating.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator - package
// Sizes, codes and transfer types shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	localparam int MAX_PAGES  = 1024;
	localparam int PAGE_BYTES = 4096;

	localparam int MAP_WORDS  = (MAX_PAGES + 31) / 32;
	localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int IDX_W      = WORD_AW + 5;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	localparam int CNT_W = 11;
	localparam logic [CNT_W-1:0] CNT_MAX        = '1;
	localparam logic [CNT_W-1:0] PAGE_COUNT_RST = CNT_W'(1024);
	localparam logic [CNT_W-1:0] RESERVED_RST   = '0;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic [0:0] {
		REG_PAGE_COUNT = 1'b0,
		REG_RESERVED   = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_NO_FREE  = 3'd1,
		STS_RESERVED = 3'd2,
		STS_NOT_USED = 3'd3,
		STS_RANGE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FCHK
	} state_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [31:0] page_addr;
	} req_t;

	typedef struct packed {
		logic [31:0]      alloc_addr;
		status_t          status;
		logic [CNT_W-1:0] free_pages;
	} rsp_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] r;
	} lim_t;

	typedef struct packed {
		logic               we;
		logic [WORD_AW-1:0] waddr;
		logic [31:0]        wdata;
	} ram_wr_t;

endpackage

`default_nettype wire

### sv/bpa_ram.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### sv/bpa_cfg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator - configuration registers
// APB register file for page and reserved counts, with clamped limits.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bpa_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [bpa_pkg::DATA_W-1:0]  pwdata,
	output logic      [bpa_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output bpa_pkg::lim_t                    lim
);

	logic [bpa_pkg::CNT_W-1:0] page_count_q;
	logic [bpa_pkg::CNT_W-1:0] reserved_q;
	logic [bpa_pkg::CNT_W-1:0] n_eff;
	bpa_pkg::reg_idx_t         idx;
	logic                      wr;

	assign idx    = bpa_pkg::reg_idx_t'(paddr[bpa_pkg::ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= bpa_pkg::PAGE_COUNT_RST;
			reserved_q   <= bpa_pkg::RESERVED_RST;
		end else if (wr) begin
			unique case (idx)
				bpa_pkg::REG_PAGE_COUNT: page_count_q <= pwdata[bpa_pkg::CNT_W-1:0];
				bpa_pkg::REG_RESERVED:   reserved_q   <= pwdata[bpa_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bpa_pkg::REG_PAGE_COUNT: prdata = bpa_pkg::DATA_W'(page_count_q);
			bpa_pkg::REG_RESERVED:   prdata = bpa_pkg::DATA_W'(reserved_q);
			default:                 prdata = '0;
		endcase
	end

	assign n_eff = (32'(page_count_q) > 32'(bpa_pkg::MAX_PAGES)) ?
		bpa_pkg::CNT_W'(bpa_pkg::MAX_PAGES) : page_count_q;

	assign lim.n = n_eff;
	assign lim.r = (reserved_q > n_eff) ? n_eff : reserved_q;

endmodule

`default_nettype wire

### sv/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator - request sequencer
// Finds the first free page or frees one page; updates bitmap words in place.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bpa_pkg::lim_t                 lim,
	input  wire logic                          start,
	input  wire bpa_pkg::req_t                 request,
	output logic                               busy,
	output logic                               done,
	output bpa_pkg::rsp_t                      result,
	output bpa_pkg::ram_wr_t                   ram_wr,
	output logic      [bpa_pkg::WORD_AW-1:0]   ram_raddr,
	input  wire logic [31:0]                   ram_rdata
);

	function automatic logic [4:0] low_one(input logic [31:0] v);
		logic [31:0] x;
		logic [31:0] m;
		logic [4:0]  p;
		x = v;
		p = '0;
		for (int k = 4; k >= 0; k--) begin
			m = (32'd1 << (1 << k)) - 32'd1;
			if ((x & m) == 32'd0) begin
				p[k] = 1'b1;
				x    = x >> (1 << k);
			end
		end
		return p;
	endfunction

	bpa_pkg::state_t               state_q, state_d;
	logic [bpa_pkg::WORD_AW-1:0]   ptr_q, ptr_d;
	logic                          first_q, first_d;
	logic [bpa_pkg::IDX_W-1:0]     idx_q, idx_d;
	logic [bpa_pkg::CNT_W-1:0]     taken_q, taken_d;
	logic [bpa_pkg::MAP_WORDS-1:0] vld_q;
	logic                          done_q, done_d;
	bpa_pkg::rsp_t                 result_q, result_d;

	logic                          accept;
	logic                          alloc_go;
	logic                          free_go;
	logic [31:0]                   free_idx;
	logic [bpa_pkg::WORD_AW-1:0]   start_word;
	logic [bpa_pkg::CNT_W-1:0]     nm1;
	logic [bpa_pkg::WORD_AW-1:0]   last_word;
	logic [31:0]                   word;
	logic [31:0]                   lo_mask;
	logic [31:0]                   hi_mask;
	logic [31:0]                   cand;
	logic                          found;
	logic [4:0]                    bit_sel;
	logic                          scan_end;
	logic [bpa_pkg::CNT_W-1:0]     avail;

	assign accept   = start && (state_q == bpa_pkg::S_IDLE);
	assign free_idx = request.page_addr >> bpa_pkg::PAGE_SHIFT;
	assign alloc_go = accept && (request.req_type == bpa_pkg::REQ_ALLOC) && (lim.r < lim.n);
	assign free_go  = accept && (request.req_type == bpa_pkg::REQ_FREE) &&
		(free_idx < 32'(lim.n)) && (free_idx >= 32'(lim.r));

	assign start_word = (request.req_type == bpa_pkg::REQ_ALLOC) ?
		bpa_pkg::WORD_AW'(lim.r >> 5) : bpa_pkg::WORD_AW'(free_idx >> 5);

	assign nm1       = lim.n - 1'b1;
	assign last_word = bpa_pkg::WORD_AW'(nm1 >> 5);

	assign word    = vld_q[ptr_q] ? ram_rdata : 32'd0;
	assign lo_mask = first_q ? ({32{1'b1}} << lim.r[4:0]) : {32{1'b1}};
	assign hi_mask = (ptr_q == last_word) ? ({32{1'b1}} >> (5'd31 - nm1[4:0])) : {32{1'b1}};
	assign cand    = ~word & lo_mask & hi_mask;
	assign found   = |cand;
	assign bit_sel = low_one(cand);
	assign scan_end = found || (ptr_q == last_word);

	assign avail = lim.n - lim.r;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (alloc_go) begin
					state_d = bpa_pkg::S_SCAN;
				end else if (free_go) begin
					state_d = bpa_pkg::S_FCHK;
				end
			end
			bpa_pkg::S_SCAN: begin
				if (scan_end) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_FCHK: state_d = bpa_pkg::S_IDLE;
			default:         state_d = bpa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ptr_d               = ptr_q;
		first_d             = first_q;
		idx_d               = idx_q;
		taken_d             = taken_q;
		done_d              = 1'b0;
		result_d.alloc_addr = '0;
		result_d.status     = bpa_pkg::STS_OK;
		ram_wr.we           = 1'b0;
		ram_wr.waddr        = ptr_q;
		ram_wr.wdata        = word;
		ram_raddr           = ptr_q + 1'b1;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				ram_raddr = start_word;
				if (accept) begin
					ptr_d   = start_word;
					first_d = 1'b1;
					idx_d   = bpa_pkg::IDX_W'(free_idx);
					if (request.req_type == bpa_pkg::REQ_ALLOC) begin
						if (!alloc_go) begin
							done_d          = 1'b1;
							result_d.status = bpa_pkg::STS_NO_FREE;
						end
					end else if (free_idx >= 32'(lim.n)) begin
						done_d          = 1'b1;
						result_d.status = bpa_pkg::STS_RANGE;
					end else if (free_idx < 32'(lim.r)) begin
						done_d          = 1'b1;
						result_d.status = bpa_pkg::STS_RESERVED;
					end
				end
			end
			bpa_pkg::S_SCAN: begin
				if (found) begin
					ram_wr.we           = 1'b1;
					ram_wr.wdata        = word | (32'd1 << bit_sel);
					done_d              = 1'b1;
					result_d.alloc_addr = 32'({ptr_q, bit_sel}) << bpa_pkg::PAGE_SHIFT;
					if (taken_q != bpa_pkg::CNT_MAX) begin
						taken_d = taken_q + 1'b1;
					end
				end else if (ptr_q == last_word) begin
					done_d          = 1'b1;
					result_d.status = bpa_pkg::STS_NO_FREE;
				end else begin
					ptr_d   = ptr_q + 1'b1;
					first_d = 1'b0;
				end
			end
			bpa_pkg::S_FCHK: begin
				done_d = 1'b1;
				if (word[idx_q[4:0]]) begin
					ram_wr.we    = 1'b1;
					ram_wr.wdata = word & ~(32'd1 << idx_q[4:0]);
					if (taken_q != '0) begin
						taken_d = taken_q - 1'b1;
					end
				end else begin
					result_d.status = bpa_pkg::STS_NOT_USED;
				end
			end
			default: ;
		endcase
		result_d.free_pages = (taken_d >= avail) ? '0 : avail - taken_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_IDLE;
			taken_q <= '0;
			vld_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			taken_q <= taken_d;
			done_q  <= done_d;
			if (ram_wr.we) begin
				vld_q[ram_wr.waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		first_q <= first_d;
		idx_q   <= idx_d;
		if (done_d) begin
			result_q <= result_d;
		end
	end

	assign busy   = (state_q != bpa_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

### sv/bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator - top level
// First-fit page allocator over a used-page bitmap held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: an allocate or free command is transferred when start is
//   high and busy is low. Result channel: done pulses for one cycle with
//   alloc_addr, status and free_pages; the receiver always takes it.
//   Registers page_count (0x0) and reserved_count (0x4) sit on APB; the user
//   writes them only while no request is in flight, unchecked by the block.
// Timing:
//   Allocate scans one bitmap word per cycle through the RAM read port, from
//   the word holding the first unreserved page, until a free bit is found or
//   the last word (of up to 32) is scanned. Free reads and writes back one
//   word. Requests rejected on the limits give done in the cycle after the
//   transfer. A new request is taken in the cycle done is shown.
// Reset:
//   Bitmap reads as all free through per-word valid flags, cleared at once;
//   the taken count is zero, page_count 1024, reserved_count 0.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire bpa_pkg::req_t               request,
	output logic                             done,
	output bpa_pkg::rsp_t                    result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bpa_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [bpa_pkg::DATA_W-1:0]  pwdata,
	output logic      [bpa_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);

	bpa_pkg::lim_t               lim;
	bpa_pkg::ram_wr_t            ram_wr;
	logic [bpa_pkg::WORD_AW-1:0] ram_raddr;
	logic [31:0]                 ram_rdata;

	bpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.lim     (lim)
	);

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.lim       (lim),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_wr    (ram_wr),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bpa_ram #(
		.WIDTH (32),
		.DEPTH (bpa_pkg::MAP_WORDS),
		.AW    (bpa_pkg::WORD_AW)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.waddr),
		.wdata (ram_wr.wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

### sv/bpa_checker.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator - port checker
// Request and result ordering seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_page_allocator_core_defines.svh"

module bpa_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire bpa_pkg::req_t request,
	input wire logic          done,
	input wire bpa_pkg::rsp_t result
);

	logic req_seen;
	logic xfer;
	logic failed;

	assign req_seen = (request.req_type == bpa_pkg::REQ_ALLOC) ||
		(request.req_type == bpa_pkg::REQ_FREE);
	assign xfer     = start && !busy;
	assign failed   = done && (result.status != bpa_pkg::STS_OK);

	`BPA_ASSERT_NXT(a_accept_busy, clk, arst_n, xfer && req_seen, busy || done, "transfer gave no work")
	`BPA_ASSERT_IMP(a_done_cause, clk, arst_n, !$past(xfer) && !$past(busy), !done, "stray result")
	`BPA_ASSERT_IMP(a_fail_addr, clk, arst_n, failed, result.alloc_addr == 32'd0, "failure with address")

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);

`default_nettype wire
